[hdl/scfp_pkg.sv]
`timescale 1ns / 1ps

package scfp_pkg;

  // Frame characters
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_GET   = 8'h67;  // 'g'
  localparam logic [7:0] CH_SET   = 8'h73;  // 's'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  // Largest mantissa a value may reach
  localparam logic [23:0] MANT_LIMIT = 24'd999999;
  localparam logic [2:0]  FRAC_MAX   = 3'd7;

  // Control word from the frame FSM to the value accumulator
  typedef struct packed {
    logic       clear;  // start a new value
    logic       take;   // store one value character
    logic [7:0] chr;    // character, comma already mapped to point
  } value_ctl_t;

  // Parameter letters accepted by a get request
  function automatic logic is_get_letter(input logic [7:0] b);
    logic hit;
    case (b) inside
      "D", "v", "m", "x", "y", "t", "b", "p", "i",
      "d", "g", "e", "l", "z", "a", "f", "o", "h": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Parameter letters accepted by a set command
  function automatic logic is_set_letter(input logic [7:0] b);
    logic hit;
    case (b) inside
      "p", "i", "d", "g", "e", "l", "z",
      "o", "f", "h", "F", "B", "L", "R": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

[hdl/scfp_if.sv]
`timescale 1ns / 1ps

// Received byte channel
interface scfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded request channel
interface scfp_req_if;
  logic        valid;
  logic        ready;
  logic        is_set;
  logic [7:0]  param_code;
  logic [19:0] value_mantissa;
  logic [2:0]  frac_digits;
  logic [7:0]  first_char;
  logic [2:0]  value_length;

  modport source (output valid, output is_set, output param_code, output value_mantissa,
                  output frac_digits, output first_char, output value_length,
                  input ready);
  modport sink   (input valid, input is_set, input param_code, input value_mantissa,
                  input frac_digits, input first_char, input value_length,
                  output ready);
endinterface

[hdl/scfp_value.sv]
`timescale 1ns / 1ps

module scfp_value #(
  parameter int MAX_VALUE_CHARS = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  scfp_pkg::value_ctl_t               ctl,
  output logic [$clog2(MAX_VALUE_CHARS+1)-1:0] char_count,
  output logic [19:0]                        mantissa,
  output logic [2:0]                         frac_count,
  output logic [7:0]                         first_char
);
  import scfp_pkg::*;

  localparam int CNT_W = $clog2(MAX_VALUE_CHARS + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [19:0]      mant_r, mant_nxt;
  logic [2:0]       frac_r, frac_nxt;
  logic             point_r, point_nxt;
  logic             ended_r, ended_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [23:0]      mant_x10;
  logic [23:0]      mant_try;

  // Candidate mantissa: times ten plus the new digit
  assign mant_x10 = {1'b0, mant_r, 3'b000} + {3'b000, mant_r, 1'b0};
  assign mant_try = mant_x10 + {20'd0, ctl.chr[3:0]};

  // Accumulate one value character
  always_comb begin
    count_nxt = count_r;
    mant_nxt  = mant_r;
    frac_nxt  = frac_r;
    point_nxt = point_r;
    ended_nxt = ended_r;
    first_nxt = first_r;
    if (ctl.clear) begin
      count_nxt = '0;
      mant_nxt  = '0;
      frac_nxt  = '0;
      point_nxt = 1'b0;
      ended_nxt = 1'b0;
      first_nxt = '0;
    end else if (ctl.take && (count_r < CNT_W'(MAX_VALUE_CHARS))) begin
      if (count_r == '0) begin
        first_nxt = ctl.chr;
      end
      count_nxt = count_r + CNT_W'(1);
      if (!ended_r) begin
        if (ctl.chr == CH_DOT) begin
          // second point ends the number
          if (point_r) begin
            ended_nxt = 1'b1;
          end else begin
            point_nxt = 1'b1;
          end
        end else if (mant_try > MANT_LIMIT) begin
          ended_nxt = 1'b1;
        end else begin
          mant_nxt = mant_try[19:0];
          if (point_r && (frac_r != FRAC_MAX)) begin
            frac_nxt = frac_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mant_r  <= '0;
      frac_r  <= '0;
      point_r <= 1'b0;
      ended_r <= 1'b0;
      first_r <= '0;
    end else begin
      count_r <= count_nxt;
      mant_r  <= mant_nxt;
      frac_r  <= frac_nxt;
      point_r <= point_nxt;
      ended_r <= ended_nxt;
      first_r <= first_nxt;
    end
  end

  assign char_count = count_r;
  assign mantissa   = mant_r;
  assign frac_count = frac_r;
  assign first_char = first_r;

endmodule

[hdl/serial_command_frame_parser.sv]
`timescale 1ns / 1ps

// Serial command frame parser. Takes one received byte per word on in_chan and
// recognizes '-' 'g' P '!' (get request) and '-' 's' P V '!' (set command);
// a '-' restarts framing anywhere, any unexpected byte drops the frame.
// On the closing '!' one request word appears on out_chan, with the value
// given as a decimal mantissa plus a count of fraction digits. A byte is
// taken every cycle while the input register can advance: it lands in an
// input register, is decoded and folded into the value in the next cycle,
// and its result is loaded into the output register at that same edge. Throughput is one byte
// per clock as long as out_chan takes results; a stalled output register
// holds back the input register, which then holds one more byte.
module serial_command_frame_parser #(
  parameter int MAX_VALUE_CHARS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  scfp_rx_if.sink           in_chan,
  scfp_req_if.source        out_chan
);
  import scfp_pkg::*;

  localparam int CNT_W = $clog2(MAX_VALUE_CHARS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READY = 3'd1;
  localparam logic [2:0] ST_GET   = 3'd2;
  localparam logic [2:0] ST_SET   = 3'd3;
  localparam logic [2:0] ST_PARAM = 3'd4;
  localparam logic [2:0] ST_VALUE = 3'd5;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_advance;

  // Frame state
  logic [2:0] state_r, state_nxt;
  logic [7:0] param_r, param_nxt;

  // Value accumulator
  value_ctl_t       vctl;
  logic [CNT_W-1:0] v_count;
  logic [19:0]      v_mant;
  logic [2:0]       v_frac;
  logic [7:0]       v_first;

  // Decode results
  logic emit_get, emit_set;
  logic is_value_char;

  // Output register
  logic        out_valid_r;
  logic        out_is_set_r;
  logic [7:0]  out_param_r;
  logic [19:0] out_mant_r;
  logic [2:0]  out_frac_r;
  logic [7:0]  out_first_r;
  logic [2:0]  out_len_r;

  // Advance the input register whenever the output register is free
  assign s1_advance    = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.rx_byte;
    end
  end

  assign is_value_char = ((s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE)) ||
                         (s1_byte_r == CH_COMMA) || (s1_byte_r == CH_DOT);

  // Frame state machine
  always_comb begin
    state_nxt  = state_r;
    param_nxt  = param_r;
    vctl.clear = 1'b0;
    vctl.take  = 1'b0;
    vctl.chr   = (s1_byte_r == CH_COMMA) ? CH_DOT : s1_byte_r;
    emit_get   = 1'b0;
    emit_set   = 1'b0;
    if (s1_advance) begin
      if (s1_byte_r == CH_DASH) begin
        state_nxt = ST_READY;
      end else begin
        unique case (state_r)
          ST_READY: begin
            if (s1_byte_r == CH_GET) begin
              state_nxt = ST_GET;
            end else if (s1_byte_r == CH_SET) begin
              state_nxt = ST_SET;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ST_GET: begin
            if (is_get_letter(s1_byte_r)) begin
              param_nxt = s1_byte_r;
              state_nxt = ST_PARAM;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ST_SET: begin
            if (is_set_letter(s1_byte_r)) begin
              param_nxt  = s1_byte_r;
              vctl.clear = 1'b1;
              state_nxt  = ST_VALUE;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          ST_PARAM: begin
            emit_get  = (s1_byte_r == CH_BANG);
            state_nxt = ST_IDLE;
          end
          ST_VALUE: begin
            if (is_value_char) begin
              vctl.take = 1'b1;
            end else begin
              emit_set  = (s1_byte_r == CH_BANG);
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            // idle and unused codes ignore noise
            state_nxt = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      param_r <= '0;
    end else begin
      state_r <= state_nxt;
      param_r <= param_nxt;
    end
  end

  scfp_value #(
    .MAX_VALUE_CHARS(MAX_VALUE_CHARS)
  ) u_value (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (vctl),
    .char_count (v_count),
    .mantissa   (v_mant),
    .frac_count (v_frac),
    .first_char (v_first)
  );

  // Output register: load on a completed frame, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= emit_get || emit_set;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_get || emit_set) begin
      out_is_set_r <= emit_set;
      out_param_r  <= param_r;
      out_mant_r   <= emit_set ? v_mant : 20'd0;
      out_frac_r   <= emit_set ? v_frac : 3'd0;
      out_first_r  <= emit_set ? v_first : 8'd0;
      out_len_r    <= emit_set ? 3'(v_count) : 3'd0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.is_set         = out_is_set_r;
  assign out_chan.param_code     = out_param_r;
  assign out_chan.value_mantissa = out_mant_r;
  assign out_chan.frac_digits    = out_frac_r;
  assign out_chan.first_char     = out_first_r;
  assign out_chan.value_length   = out_len_r;

  // A new result only follows a closing '!'
  a_emit_on_bang: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_byte_r) == CH_BANG)
    else $error("result without closing byte");

  // Get requests carry an empty value
  a_get_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_set_r) |->
      (out_mant_r == 20'd0) && (out_frac_r == 3'd0) &&
      (out_first_r == 8'd0) && (out_len_r == 3'd0))
    else $error("get request with value");

  // A held input byte is not overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_advance) |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a byte");

endmodule
